>>> design/fir_lp_pkg.sv
// Shared types, constants and coefficient ROM for the low-pass FIR core.
package fir_lp_pkg;

	localparam int COEF_W    = 18;
	localparam int FRAC_BITS = 20;
	localparam int ROM_TAPS  = 64;
	localparam int ROM_IDX_W = 8;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;   // capture sample, write history, clear accumulator
		logic issue;   // read one tap and its coefficient
		logic finish;  // round, saturate and load the output register
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last_tap;  // tap being issued is the final one
		logic out_free;  // output register empty or being emptied
	} ctl_status_t;

	// Coefficients: ideal value times 2^20, rounded; taps past the ROM are zero
	function automatic logic signed [COEF_W-1:0] coef_rom(input logic [ROM_IDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		case (idx)
			8'd0:  c = -18'sd33;
			8'd1:  c = 18'sd128;
			8'd2:  c = 18'sd211;
			8'd3:  c = 18'sd366;
			8'd4:  c = 18'sd595;
			8'd5:  c = 18'sd911;
			8'd6:  c = 18'sd1331;
			8'd7:  c = 18'sd1875;
			8'd8:  c = 18'sd2559;
			8'd9:  c = 18'sd3401;
			8'd10: c = 18'sd4417;
			8'd11: c = 18'sd5619;
			8'd12: c = 18'sd7016;
			8'd13: c = 18'sd8613;
			8'd14: c = 18'sd10409;
			8'd15: c = 18'sd12398;
			8'd16: c = 18'sd14568;
			8'd17: c = 18'sd16899;
			8'd18: c = 18'sd19366;
			8'd19: c = 18'sd21936;
			8'd20: c = 18'sd24574;
			8'd21: c = 18'sd27235;
			8'd22: c = 18'sd29874;
			8'd23: c = 18'sd32442;
			8'd24: c = 18'sd34888;
			8'd25: c = 18'sd37162;
			8'd26: c = 18'sd39216;
			8'd27: c = 18'sd41004;
			8'd28: c = 18'sd42487;
			8'd29: c = 18'sd43631;
			8'd30: c = 18'sd44408;
			8'd31: c = 18'sd44802;
			8'd32: c = 18'sd44802;
			8'd33: c = 18'sd44408;
			8'd34: c = 18'sd43631;
			8'd35: c = 18'sd42487;
			8'd36: c = 18'sd41004;
			8'd37: c = 18'sd39216;
			8'd38: c = 18'sd37162;
			8'd39: c = 18'sd34888;
			8'd40: c = 18'sd32442;
			8'd41: c = 18'sd29874;
			8'd42: c = 18'sd27235;
			8'd43: c = 18'sd24574;
			8'd44: c = 18'sd21936;
			8'd45: c = 18'sd19366;
			8'd46: c = 18'sd16899;
			8'd47: c = 18'sd14568;
			8'd48: c = 18'sd12398;
			8'd49: c = 18'sd10409;
			8'd50: c = 18'sd8613;
			8'd51: c = 18'sd7016;
			8'd52: c = 18'sd5619;
			8'd53: c = 18'sd4417;
			8'd54: c = 18'sd3401;
			8'd55: c = 18'sd2559;
			8'd56: c = 18'sd1875;
			8'd57: c = 18'sd1331;
			8'd58: c = 18'sd911;
			8'd59: c = 18'sd595;
			8'd60: c = 18'sd366;
			8'd61: c = 18'sd211;
			8'd62: c = 18'sd128;
			8'd63: c = -18'sd33;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> design/fir_lp_sample_if.sv
// Input sample channel: valid/ready handshake with the sample payload.
interface fir_lp_sample_if #(
	parameter int WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

>>> design/fir_lp_filtered_if.sv
// Output result channel: valid/ready handshake with the filtered payload.
interface fir_lp_filtered_if #(
	parameter int WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] filtered_out;

	modport source (output valid, output filtered_out, input ready);
	modport sink (input valid, input filtered_out, output ready);
endinterface

>>> design/fir_lp_ctrl.sv
// Sequencing state machine for the FIR core.
module fir_lp_ctrl
	import fir_lp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ctl_status_t sts,
	output ctl_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (sts.last_tap) state_q <= ST_DRAIN1;
				end
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.issue  = (state_q == ST_RUN);
	assign cmd.finish = (state_q == ST_FINISH) && sts.out_free;

endmodule

>>> design/fir_lp_dpath.sv
// History memory, coefficient fetch, MAC pipeline and output register.
module fir_lp_dpath
	import fir_lp_pkg::*;
#(
	parameter int TAP_COUNT    = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctl_cmd_t                       cmd,
	output ctl_status_t                    sts,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [SAMPLE_WIDTH-1:0] filtered_out,
	output logic                           out_valid,
	input  logic                           out_ready
);

	localparam int AW     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int FW     = $clog2(TAP_COUNT + 1);
	localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
	localparam logic [AW-1:0] LAST_IDX = AW'(TAP_COUNT - 1);
	localparam logic [FW-1:0] FULL     = FW'(TAP_COUNT);
	localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W:0] MAX_V =
		{{(ACC_W+2-SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W:0] MIN_V =
		{{(ACC_W+2-SAMPLE_WIDTH){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

	// Ring of the newest TAP_COUNT samples; the fill count masks unwritten slots
	logic signed [SAMPLE_WIDTH-1:0] mem_q [TAP_COUNT];

	logic [AW-1:0] wptr_q, rptr_q, k_q;
	logic [FW-1:0] fill_q;
	logic          iss_s1, iss_s2;
	logic          out_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] rdata_s1;
	logic signed [COEF_W-1:0]       coef_s1;
	logic                           tapv_s1;
	logic signed [PROD_W-1:0]       prod_s2;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;

	logic signed [ACC_W:0]          biased, shifted;
	logic signed [SAMPLE_WIDTH-1:0] sat_val;

	always_ff @(posedge clk) begin
		if (cmd.start) mem_q[wptr_q] <= sample_in;
		if (cmd.issue) rdata_s1 <= mem_q[rptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			k_q         <= '0;
			fill_q      <= '0;
			iss_s1      <= 1'b0;
			iss_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			iss_s1 <= cmd.issue;
			iss_s2 <= iss_s1;
			if (cmd.start) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
				rptr_q <= wptr_q;
				k_q    <= '0;
				if (fill_q != FULL) fill_q <= fill_q + 1'b1;
			end else if (cmd.issue) begin
				rptr_q <= (rptr_q == '0) ? LAST_IDX : rptr_q - 1'b1;
				k_q    <= k_q + 1'b1;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Coefficient, tap mask, product and accumulation
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			coef_s1 <= coef_rom(ROM_IDX_W'(k_q));
			tapv_s1 <= (FW'(k_q) < fill_q);
		end
		if (tapv_s1) prod_s2 <= coef_s1 * rdata_s1;
		else         prod_s2 <= '0;
		if (cmd.start) acc_q <= '0;
		else if (iss_s2) acc_q <= acc_q + ACC_W'(prod_s2);
		if (cmd.finish) filtered_q <= sat_val;
	end

	always_comb begin
		biased  = (ACC_W+1)'(acc_q) + RND;
		shifted = biased >>> FRAC_BITS;
		if (shifted > MAX_V)      sat_val = MAX_V[SAMPLE_WIDTH-1:0];
		else if (shifted < MIN_V) sat_val = MIN_V[SAMPLE_WIDTH-1:0];
		else                      sat_val = shifted[SAMPLE_WIDTH-1:0];
	end

	assign sts.last_tap = (k_q == LAST_IDX);
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign filtered_out = filtered_q;

endmodule

>>> design/fir_lowpass_64_tap_core.sv
// Top level of the 64-tap symmetric low-pass FIR core.
//
//   channel     dir   payload                      transaction when
//   sample_ch   in    sample_in    [SW-1:0] s      valid && ready
//   result_ch   out   filtered_out [SW-1:0] s      valid && ready
//
// After the sample's transaction the controller issues every tap in ST_RUN,
// drains the MAC pipeline in ST_DRAIN1 and ST_DRAIN2 and loads the output
// register in ST_FINISH. One MAC serves every tap, fed by a single read port
// of the history memory, one tap per cycle. A new sample is taken only once
// the previous result has been loaded into the output register.
// Reset clears the fill count and control state at once; history slots
// never written since reset are masked by the fill count: no clearing pass.
// The output register holds a result while the sink stalls; the next
// sample is taken meanwhile and its result waits for the register to free.
module fir_lowpass_64_tap_core
	import fir_lp_pkg::*;
#(
	parameter int TAP_COUNT    = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	fir_lp_sample_if.sink      sample_ch,
	fir_lp_filtered_if.source  result_ch
);

	ctl_cmd_t    cmd;
	ctl_status_t sts;

	// Sequence accept, tap issue, pipeline drain and output load
	fir_lp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold history, multiply-accumulate, round and saturate
	fir_lp_dpath #(
		.TAP_COUNT    (TAP_COUNT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_in    (sample_ch.sample_in),
		.filtered_out (result_ch.filtered_out),
		.out_valid    (result_ch.valid),
		.out_ready    (result_ch.ready)
	);

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 64-tap low-pass FIR core: prediction, stimulus and checks.
module testbench;
	import fir_lp_pkg::*;

	localparam int TAPS        = 64;
	localparam int SAMPLE_W    = 16;
	localparam int SAMPLE_GOAL = 1650;
	// Allow a generous margin after the last result.
	localparam int TAIL_CYCLES = 2 * (TAPS + 4);
	// Longest correct silence: the long sink hold plus the processing of a sample.
	localparam int HOLD_CYCLES = 600;
	localparam int IDLE_LIMIT  = 4000;

	localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Shapes of random stimulus segments
	typedef enum int {
		SEG_WILD,    // every bit random
		SEG_RAIL,    // a long run at one full-scale rail, drives the sum into saturation
		SEG_QUIET,   // small values around zero
		SEG_LEVEL,   // a random constant level, lets the filter settle
		SEG_TOGGLE   // full-scale alternation, the stop band of the filter
	} segment_kind_e;

	// Predicts the filter output for every accepted sample and holds the
	// outputs still owed by the core, oldest first.
	class lowpass_scoreboard;
		int      weights[TAPS];
		sample_t history[TAPS-1];
		sample_t pending_outputs[$];
		int      mismatches;
		int      checked;
		int      saturated;

		function new();
			weights = '{
				-33, 128, 211, 366, 595, 911, 1331, 1875,
				2559, 3401, 4417, 5619, 7016, 8613, 10409, 12398,
				14568, 16899, 19366, 21936, 24574, 27235, 29874, 32442,
				34888, 37162, 39216, 41004, 42487, 43631, 44408, 44802,
				44802, 44408, 43631, 42487, 41004, 39216, 37162, 34888,
				32442, 29874, 27235, 24574, 21936, 19366, 16899, 14568,
				12398, 10409, 8613, 7016, 5619, 4417, 3401, 2559,
				1875, 1331, 911, 595, 366, 211, 128, -33
			};
			foreach (history[i])
				history[i] = '0;
			mismatches = 0;
			checked    = 0;
			saturated  = 0;
		endfunction

		// Full-width sum of products, round half up, floor-shift, saturate; then shift history.
		function sample_t filter_output(input sample_t x);
			longint acc;
			longint rounded;
			acc = longint'(weights[0]) * longint'(x);
			for (int k = 1; k < TAPS; k++)
				acc += longint'(weights[k]) * longint'(history[k-1]);
			rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (rounded > OUT_MAX) begin
				rounded = OUT_MAX;
				saturated++;
			end else if (rounded < OUT_MIN) begin
				rounded = OUT_MIN;
				saturated++;
			end
			for (int k = TAPS - 2; k > 0; k--)
				history[k] = history[k-1];
			history[0] = x;
			return rounded[SAMPLE_W-1:0];
		endfunction

		function void note_sample(input sample_t x);
			pending_outputs = {pending_outputs, filter_output(x)};
		endfunction

		function void check_filtered(input sample_t actual);
			sample_t want;
			checked++;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: filtered_out %0d arrived with no sample outstanding",
						$time, actual);
				return;
			end
			want = pending_outputs.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: filtered_out mismatch on output %0d: expected %0d, actual %0d",
						$time, checked, want, actual);
			end
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fir_lp_sample_if   #(.WIDTH(SAMPLE_W)) sample_ch ();
	fir_lp_filtered_if #(.WIDTH(SAMPLE_W)) result_ch ();

	fir_lowpass_64_tap_core #(
		.TAP_COUNT    (TAPS),
		.SAMPLE_WIDTH (SAMPLE_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	lowpass_scoreboard sb = new();

	int samples_sent   = 0;
	int quiet_cycles   = 0;
	bit steady         = 1'b0;  // both sides run without gaps while set
	bit sink_hold_req  = 1'b0;  // ask the receiver for one long hold-off
	int sink_holds     = 0;
	int drained_pauses = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 150);
	endfunction

	// Offer one sample, hold it until the core takes it, then idle for a random gap.
	// Valid stays high across back-to-back transactions.
	task automatic send_sample(input sample_t value);
		int gap;
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_in <= value;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		samples_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering samples and wait until every predicted output has arrived.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic sample_t segment_value(input segment_kind_e kind, input int idx,
		input sample_t level);
		case (kind)
			SEG_WILD:   return sample_t'($urandom);
			SEG_RAIL:   return level;
			SEG_QUIET:  return sample_t'($urandom_range(0, 600) - 300);
			SEG_LEVEL:  return level;
			SEG_TOGGLE: return idx[0] ? sample_t'(OUT_MIN) : sample_t'(OUT_MAX);
			default:    return '0;
		endcase
	endfunction

	// Receiver: random ready pattern, plus one long hold-off on request that lets the
	// core fill up and push back on the sample channel.
	initial begin
		int run;
		int gap;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_holds++;
			end
			result_ch.ready <= 1'b1;
			run = $urandom_range(1, 20);
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Monitor: feed accepted samples to the predictor, check accepted outputs,
	// and end the run if the channels go silent for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				sb.note_sample(sample_ch.sample_in);
			if (result_ch.valid && result_ch.ready)
				sb.check_filtered(result_ch.filtered_out);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d outputs outstanding",
					$time, IDLE_LIMIT, sb.pending());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		segment_kind_e kind;
		sample_t       level;
		int            seg_len;
		sample_t       directed[$];
		sample_ch.valid     <= 1'b0;
		sample_ch.sample_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first samples after reset see an empty history; extremes, zero,
		// +1 and -1, alternating-bit patterns, then a run at the positive rail.
		directed = {sample_t'(OUT_MIN), sample_t'(OUT_MAX), sample_t'(16'sh0000),
			sample_t'(16'sh0001), sample_t'(-16'sh0001), sample_t'(16'sh5555),
			sample_t'(16'hAAAA)};
		repeat (18)
			directed = {directed, sample_t'(OUT_MAX)};
		foreach (directed[i])
			send_sample(directed[i]);

		// Random segments of varied shape and length
		while (samples_sent < SAMPLE_GOAL) begin
			kind   = segment_kind_e'($urandom_range(0, 4));
			steady = ($urandom_range(0, 5) == 0);
			case (kind)
				SEG_RAIL: begin
					level   = $urandom_range(0, 1) ? sample_t'(OUT_MAX) : sample_t'(OUT_MIN);
					seg_len = $urandom_range(64, 100);
				end
				SEG_LEVEL: begin
					level   = sample_t'($urandom);
					seg_len = $urandom_range(40, 80);
				end
				default: begin
					level   = '0;
					seg_len = $urandom_range(8, 60);
				end
			endcase
			for (int i = 0; i < seg_len && samples_sent < SAMPLE_GOAL; i++) begin
				// Hold the sink off once while samples keep coming.
				if (samples_sent == 600 && sink_holds == 0 && !sink_hold_req)
					sink_hold_req = 1'b1;
				// Pause once until the core has delivered everything.
				if (samples_sent == 1100 && drained_pauses == 0) begin
					wait_drained();
					drained_pauses++;
				end
				send_sample(segment_value(kind, i, level));
			end
		end
		steady = 1'b0;

		// Drain, then give any stray output time to show up.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d samples, checked %0d filtered outputs (%0d saturated).",
			samples_sent, sb.checked, sb.saturated);
		$display("Long sink hold-offs: %0d, drained pauses: %0d, mismatches: %0d.",
			sink_holds, drained_pauses, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			if (sb.pending() != 0)
				$display("%0d predicted outputs never arrived", sb.pending());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
